/* hdl/brti_pkg.sv */
`timescale 1ns / 1ps

package brti_pkg;

   localparam int IDX_BITS      = 10;
   localparam int FRAC_MAX_BITS = 16;
   localparam int CMDQ_DEPTH    = 4;
   localparam int CMDQ_PTR_BITS = 2;
   localparam int OUTQ_DEPTH    = 8;
   localparam int OUTQ_PTR_BITS = 3;
   localparam int LEVEL_BITS    = 4;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  row_index;
      logic [7:0]  col_index;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
      logic [14:0] incident_angle;
      logic [15:0] outgoing_angle;
   } req_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic                     is_lookup;
      logic                     write_en;
      logic [IDX_BITS-1:0]      row0;
      logic [IDX_BITS-1:0]      row1;
      logic [IDX_BITS-1:0]      col0;
      logic [IDX_BITS-1:0]      col1;
      logic [FRAC_MAX_BITS-1:0] row_frac;
      logic [FRAC_MAX_BITS-1:0] col_frac;
      logic [15:0]              red;
      logic [15:0]              green;
      logic [15:0]              blue;
   } cmd_type;

endpackage

/* hdl/brti_front.sv */
`timescale 1ns / 1ps

module brti_front #(
   parameter int ROWS      = 91,
   parameter int COLS      = 181,
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  brti_pkg::req_type req_word,
   output logic              cmd_valid,
   output brti_pkg::cmd_type cmd_word,
   input  logic              cmd_pop
);
   import brti_pkg::*;

   localparam logic [31:0] ROW_LAST = 32'(ROWS - 1);
   localparam logic [31:0] COL_LAST = 32'(COLS - 1);
   localparam logic [31:0] FRAC_MASK = (32'(1) << FRAC_BITS) - 32'(1);

   logic [31:0] row_ext, row_ip, row_fp, row_hi;
   logic [31:0] col_ext, col_ip, col_fp, col_hi;
   cmd_type     cmd_in;

   cmd_type                cmdq [CMDQ_DEPTH];
   logic [CMDQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_PTR_BITS:0]   count_ff, count_in;
   logic                     accept;

   always_comb begin
      row_ext = 32'(req_word.incident_angle);
      row_ip  = row_ext >> FRAC_BITS;
      row_fp  = row_ext & FRAC_MASK;
      // past the last row: clamp and drop the fraction
      if (row_ip > ROW_LAST) begin
         row_ip = ROW_LAST;
         row_fp = '0;
      end
      row_hi = (row_ip + 32'(1) > ROW_LAST) ? ROW_LAST : row_ip + 32'(1);

      col_ext = 32'(req_word.outgoing_angle);
      col_ip  = col_ext >> FRAC_BITS;
      col_fp  = col_ext & FRAC_MASK;
      if (col_ip > COL_LAST) begin
         col_ip = COL_LAST;
         col_fp = '0;
      end
      col_hi = (col_ip + 32'(1) > COL_LAST) ? COL_LAST : col_ip + 32'(1);

      cmd_in.is_lookup = (req_word.op == OP_LOOKUP);
      cmd_in.row_frac  = FRAC_MAX_BITS'(row_fp);
      cmd_in.col_frac  = FRAC_MAX_BITS'(col_fp);
      cmd_in.red       = req_word.red_in;
      cmd_in.green     = req_word.green_in;
      cmd_in.blue      = req_word.blue_in;
      if (cmd_in.is_lookup) begin
         cmd_in.write_en = 1'b0;
         cmd_in.row0     = IDX_BITS'(row_ip);
         cmd_in.row1     = IDX_BITS'(row_hi);
         cmd_in.col0     = IDX_BITS'(col_ip);
         cmd_in.col1     = IDX_BITS'(col_hi);
      end else begin
         // out-of-range writes are dropped
         cmd_in.write_en = (32'(req_word.row_index) <= ROW_LAST) &&
                           (32'(req_word.col_index) <= COL_LAST);
         cmd_in.row0     = IDX_BITS'(req_word.row_index);
         cmd_in.row1     = IDX_BITS'(req_word.row_index);
         cmd_in.col0     = IDX_BITS'(req_word.col_index);
         cmd_in.col1     = IDX_BITS'(req_word.col_index);
      end
   end

   assign full      = (count_ff == (CMDQ_PTR_BITS + 1)'(CMDQ_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != '0);
   assign cmd_word  = cmdq[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + CMDQ_PTR_BITS'(accept);
      rd_ptr_in = rd_ptr_ff + CMDQ_PTR_BITS'(cmd_pop);
      count_in  = count_ff + (CMDQ_PTR_BITS + 1)'(accept) - (CMDQ_PTR_BITS + 1)'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmdq[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

/* hdl/brti_back.sv */
`timescale 1ns / 1ps

module brti_back #(
   parameter int ROWS         = 91,
   parameter int COLS         = 181,
   parameter int FRAC_BITS    = 8,
   parameter int CHANNEL_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   input  brti_pkg::cmd_type                cmd_word,
   output logic                             cmd_pop,
   input  logic [brti_pkg::LEVEL_BITS-1:0]  outq_level,
   output logic                             rsp_push,
   output brti_pkg::rsp_type                rsp_data
);
   import brti_pkg::*;

   localparam int SB         = (CHANNEL_BITS < 16) ? CHANNEL_BITS : 16;
   localparam int HALF_ROWS  = (ROWS + 1) / 2;
   localparam int HALF_COLS  = (COLS + 1) / 2;
   localparam int BANK_DEPTH = HALF_ROWS * HALF_COLS;
   localparam int AB         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int WB         = FRAC_BITS + 1;
   localparam int AW         = SB + FRAC_BITS;
   localparam int VW         = SB + 2 * FRAC_BITS;
   localparam logic [WB-1:0] FRAC_ONE   = WB'(1) << FRAC_BITS;
   localparam logic [VW:0]   ROUND_HALF = (VW + 1)'(1) << (2 * FRAC_BITS - 1);

   // issue stage: bank addresses; banks split by row and column parity
   logic [IDX_BITS-1:0] row_sel [4];
   logic [IDX_BITS-1:0] col_sel [4];
   logic [AB-1:0]       s1_addr_in [4];
   logic [AB-1:0]       s1_addr_ff [4];
   logic [3:0]          s1_we_in, s1_we_ff;
   logic                s1_valid_in, s1_valid_ff;
   logic [3*SB-1:0]     s1_wdata_ff;
   logic [FRAC_BITS-1:0] s1_fr_ff, s1_fc_ff;
   logic [3:0]          s1_par_ff;
   logic [2:0]          inflight;
   logic                credit_ok;

   // read stage
   logic [3*SB-1:0]      rd_ff [4];
   logic                 m_valid_ff;
   logic [FRAC_BITS-1:0] m_fr_ff, m_fc_ff;
   logic [3:0]           m_par_ff;

   // row-axis stage
   logic [SB-1:0]        v00, v10, v01, v11;
   logic [WB-1:0]        m_whi, m_wlo;
   logic [AW-1:0]        a0_in [3], a1_in [3], a0_ff [3], a1_ff [3];
   logic                 a_valid_ff;
   logic [FRAC_BITS-1:0] a_fc_ff;

   // column-axis stage
   logic [WB-1:0]        a_whi, a_wlo;
   logic [VW-1:0]        v_in [3], v_ff [3];
   logic                 v_valid_ff;
   logic [VW:0]          rounded [3];
   logic [SB-1:0]        res [3];

   assign inflight  = 3'(s1_valid_ff) + 3'(m_valid_ff) + 3'(a_valid_ff) + 3'(v_valid_ff);
   assign credit_ok = (5'(outq_level) + 5'(inflight)) < 5'(OUTQ_DEPTH);
   assign cmd_pop   = cmd_valid && (!cmd_word.is_lookup || credit_ok);
   assign s1_valid_in = cmd_pop && cmd_word.is_lookup;

   always_comb begin
      for (int b = 0; b < 4; b++) begin
         row_sel[b] = (cmd_word.row0[0] == b[1]) ? cmd_word.row0 : cmd_word.row1;
         col_sel[b] = (cmd_word.col0[0] == b[0]) ? cmd_word.col0 : cmd_word.col1;
         s1_addr_in[b] = AB'(32'(row_sel[b] >> 1) * 32'(HALF_COLS) + 32'(col_sel[b] >> 1));
         s1_we_in[b] = cmd_pop && !cmd_word.is_lookup && cmd_word.write_en &&
                       (cmd_word.row0[0] == b[1]) && (cmd_word.col0[0] == b[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_we_ff    <= '0;
         m_valid_ff  <= 1'b0;
         a_valid_ff  <= 1'b0;
         v_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_we_ff    <= s1_we_in;
         m_valid_ff  <= s1_valid_ff;
         a_valid_ff  <= m_valid_ff;
         v_valid_ff  <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff  <= s1_addr_in;
      s1_wdata_ff <= {cmd_word.blue[SB-1:0], cmd_word.green[SB-1:0], cmd_word.red[SB-1:0]};
      s1_fr_ff    <= cmd_word.row_frac[FRAC_BITS-1:0];
      s1_fc_ff    <= cmd_word.col_frac[FRAC_BITS-1:0];
      s1_par_ff   <= {cmd_word.row0[0], cmd_word.row1[0], cmd_word.col0[0], cmd_word.col1[0]};
      m_fr_ff     <= s1_fr_ff;
      m_fc_ff     <= s1_fc_ff;
      m_par_ff    <= s1_par_ff;
      a0_ff       <= a0_in;
      a1_ff       <= a1_in;
      a_fc_ff     <= m_fc_ff;
      v_ff        <= v_in;
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [3*SB-1:0] mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (s1_we_ff[b]) begin
            mem[s1_addr_ff[b]] <= s1_wdata_ff;
         end
         rd_ff[b] <= mem[s1_addr_ff[b]];
      end
   end

   // par bits: row0, row1, col0, col1; a clamped edge reuses the same bank
   assign m_whi = WB'(m_fr_ff);
   assign m_wlo = FRAC_ONE - m_whi;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         v00 = rd_ff[{m_par_ff[3], m_par_ff[1]}][ch*SB +: SB];
         v10 = rd_ff[{m_par_ff[2], m_par_ff[1]}][ch*SB +: SB];
         v01 = rd_ff[{m_par_ff[3], m_par_ff[0]}][ch*SB +: SB];
         v11 = rd_ff[{m_par_ff[2], m_par_ff[0]}][ch*SB +: SB];
         a0_in[ch] = AW'(v00) * AW'(m_wlo) + AW'(v10) * AW'(m_whi);
         a1_in[ch] = AW'(v01) * AW'(m_wlo) + AW'(v11) * AW'(m_whi);
      end
   end

   assign a_whi = WB'(a_fc_ff);
   assign a_wlo = FRAC_ONE - a_whi;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         v_in[ch] = VW'(a0_ff[ch]) * VW'(a_wlo) + VW'(a1_ff[ch]) * VW'(a_whi);
      end
   end

   // weights sum to one, so the rounded value never exceeds the channel range
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         rounded[ch] = (VW + 1)'(v_ff[ch]) + ROUND_HALF;
         res[ch]     = rounded[ch][2*FRAC_BITS +: SB];
      end
   end

   assign rsp_push           = v_valid_ff;
   assign rsp_data.red_out   = 16'(res[0]);
   assign rsp_data.green_out = 16'(res[1]);
   assign rsp_data.blue_out  = 16'(res[2]);

endmodule

/* hdl/brti_outq.sv */
`timescale 1ns / 1ps

module brti_outq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  brti_pkg::rsp_type               push_word,
   output logic [brti_pkg::LEVEL_BITS-1:0] level,
   output logic                            empty,
   input  logic                            pop,
   output brti_pkg::rsp_type               rsp_word
);
   import brti_pkg::*;

   rsp_type                  store [OUTQ_DEPTH];
   logic [OUTQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LEVEL_BITS-1:0]    count_ff, count_in;
   logic                     take;

   assign empty    = (count_ff == '0);
   assign take     = pop && !empty;
   assign level    = count_ff;
   assign rsp_word = store[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_PTR_BITS'(push);
      rd_ptr_in = rd_ptr_ff + OUTQ_PTR_BITS'(take);
      count_in  = count_ff + LEVEL_BITS'(push) - LEVEL_BITS'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // the back end only issues a lookup when space is reserved here
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* hdl/bilinear_rgb_table_interpolator.sv */
`timescale 1ns / 1ps
// bilinear rgb table interpolator
// request side is a queue: drive req_word and push; the word is taken when
// full is low. op selects a table write (no response) or a lookup.
// response side is a queue: while empty is low rsp_word holds the oldest
// interpolated colour; pop takes it.
// one request is accepted per cycle, write or lookup, while pop keeps up.
// a lookup passes through the command queue, bank address issue, a
// registered read of four banks, row-axis products and column-axis
// products with rounding into the response queue.
// the table is split into four banks by row and column parity so the four
// neighbours of a lookup are read in the same cycle, one port per bank.
// when pop is held low the response queue fills; lookups then wait in the
// command queue and full rises once that holds four words.
// reset empties both queues and the pipeline; table contents are not
// cleared, and a lookup must only touch entries already written.
module bilinear_rgb_table_interpolator #(
   parameter int ROWS         = 91,
   parameter int COLS         = 181,
   parameter int FRAC_BITS    = 8,
   parameter int CHANNEL_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  brti_pkg::req_type req_word,
   output logic              empty,
   input  logic              pop,
   output brti_pkg::rsp_type rsp_word
);
   import brti_pkg::*;

   logic                  cmd_valid;
   cmd_type               cmd_word;
   logic                  cmd_pop;
   logic [LEVEL_BITS-1:0] outq_level;
   logic                  rsp_push;
   rsp_type               rsp_data;

   brti_front #(
      .ROWS      (ROWS),
      .COLS      (COLS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_pop   (cmd_pop)
   );

   brti_back #(
      .ROWS         (ROWS),
      .COLS         (COLS),
      .FRAC_BITS    (FRAC_BITS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_word   (cmd_word),
      .cmd_pop    (cmd_pop),
      .outq_level (outq_level),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data)
   );

   brti_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_data),
      .level     (outq_level),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

endmodule
